// ----- rtl/gsad_pkg.sv -----
// Shared types, constants and tables for the splat attribute decoder.
// Used by gsad_engine and gaussian_splat_attribute_decode; depends on nothing.
`default_nettype none

package gsad_pkg;

   localparam int unsigned POS_W    = 20;
   localparam int unsigned LOG_W    = 16;
   localparam int unsigned QLANE_W  = 16;
   localparam int unsigned CLANE_W  = 12;
   localparam int unsigned CIN_W    = 16;
   localparam int unsigned BONE_W   = 8;
   localparam int unsigned OPAC_W   = 13;
   localparam int unsigned CSR_IDX_W = 3;

   // Register indexes of the control port
   localparam logic [CSR_IDX_W-1:0] CSR_HAS_SCALE    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HAS_ROTATION = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HAS_COLOR    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_COLOR_IS_SH  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_HAS_OPACITY  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_HAS_BONE     = 3'd5;

   // ln2 in Q30 and the floor of 2^44 / ln2_q30 for the range reduction
   localparam logic [29:0] LN2_Q30   = 30'd744261118;
   localparam logic [14:0] RECIP_LN2 = 15'((64'd1 << 44) / 64'd744261118);

   localparam logic signed [15:0] SCALE_SAT_LOG = 16'sd4352;
   localparam logic [15:0] DEFAULT_SCALE = 16'd10;
   localparam logic [15:0] SCALE_MAX     = 16'hFFFF;
   localparam logic [14:0] SH_C0_Q16     = 15'd18487;
   localparam logic [12:0] OPACITY_ONE   = 13'd4096;
   localparam logic [15:0] QUAT_ONE      = 16'd16384;
   localparam logic [11:0] COLOR_MAX     = 12'd4095;
   localparam logic [3:0]  TAYLOR_TERMS  = 4'd12;

   localparam logic [POS_W-1:0] LANE_POS_MAX = 20'h7FFFF;
   localparam logic [POS_W-1:0] LANE_NEG_MAX = 20'h80000;

   typedef struct packed {
      logic [2:0][15:0] log_scale;
      logic [15:0]      opacity_logit;
      logic [63:0]      rotation_raw;
      logic             has_scale;
      logic             has_rotation;
      logic             has_opacity;
   } gsad_job_type;

   typedef struct packed {
      logic [2:0][15:0] scale;
      logic [3:0][15:0] rotation;
      logic [12:0]      opacity;
      logic [15:0]      importance;
   } gsad_res_type;

   // ceil(2^34 / k): exact floor division by k for dividends below 2^30
   function automatic logic [33:0] taylor_recip(input logic [3:0] k);
      logic [33:0] r;
      unique case (k)
         4'd2:    r = 34'(((64'd1 << 34) + 64'd1) / 64'd2);
         4'd3:    r = 34'(((64'd1 << 34) + 64'd2) / 64'd3);
         4'd4:    r = 34'(((64'd1 << 34) + 64'd3) / 64'd4);
         4'd5:    r = 34'(((64'd1 << 34) + 64'd4) / 64'd5);
         4'd6:    r = 34'(((64'd1 << 34) + 64'd5) / 64'd6);
         4'd7:    r = 34'(((64'd1 << 34) + 64'd6) / 64'd7);
         4'd8:    r = 34'(((64'd1 << 34) + 64'd7) / 64'd8);
         4'd9:    r = 34'(((64'd1 << 34) + 64'd8) / 64'd9);
         4'd10:   r = 34'(((64'd1 << 34) + 64'd9) / 64'd10);
         4'd11:   r = 34'(((64'd1 << 34) + 64'd10) / 64'd11);
         4'd12:   r = 34'(((64'd1 << 34) + 64'd11) / 64'd12);
         default: r = 34'd0;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/gsad_engine.sv -----
// Sequencer around one shared multiplier and shift-subtract divide and square-root loops:
// exp, sigmoid, isqrt, divide and importance. Depends on gsad_pkg.
`default_nettype none

module gsad_engine (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire gsad_pkg::gsad_job_type job,
   input  wire logic                  ack,
   output logic                       done,
   output gsad_pkg::gsad_res_type     res
);

   localparam logic [4:0] ST_IDLE   = 5'd0;
   localparam logic [4:0] ST_JOB    = 5'd1;
   localparam logic [4:0] ST_RED1   = 5'd2;
   localparam logic [4:0] ST_RED2   = 5'd3;
   localparam logic [4:0] ST_FIX    = 5'd4;
   localparam logic [4:0] ST_T1     = 5'd5;
   localparam logic [4:0] ST_T2     = 5'd6;
   localparam logic [4:0] ST_T3     = 5'd7;
   localparam logic [4:0] ST_SHIFT  = 5'd8;
   localparam logic [4:0] ST_DIV    = 5'd9;
   localparam logic [4:0] ST_DIVEND = 5'd10;
   localparam logic [4:0] ST_SQ     = 5'd11;
   localparam logic [4:0] ST_SQA    = 5'd12;
   localparam logic [4:0] ST_SQCHK  = 5'd13;
   localparam logic [4:0] ST_SQRT   = 5'd14;
   localparam logic [4:0] ST_QSET   = 5'd15;
   localparam logic [4:0] ST_IMP1   = 5'd16;
   localparam logic [4:0] ST_IMP2   = 5'd17;
   localparam logic [4:0] ST_DONE   = 5'd18;

   localparam logic [2:0] JOB_SIG  = 3'd3;
   localparam logic [2:0] JOB_QUAT = 3'd4;

   logic [4:0]  state_ff, state_in;
   logic [2:0]  job_ff, job_in;
   logic [16:0] t_ff, t_in;
   logic [7:0]  n_ff, n_in;
   logic [37:0] r_ff, r_in;
   logic [30:0] term_ff, term_in;
   logic [31:0] sum_ff, sum_in;
   logic [3:0]  k_ff, k_in;
   logic [67:0] prod_ff, prod_in;
   logic [47:0] rem_ff, rem_in;
   logic [47:0] dsh_ff, dsh_in;
   logic [15:0] quo_ff, quo_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic [32:0] ss_ff, ss_in;
   logic [1:0]  lane_ff, lane_in;
   logic [48:0] sq_v_ff, sq_v_in;
   logic [49:0] sq_res_ff, sq_res_in;
   logic [48:0] sq_bit_ff, sq_bit_in;
   logic [24:0] nrm_ff, nrm_in;
   logic        neg_ff, neg_in;
   gsad_pkg::gsad_res_type res_ff, res_in;

   logic [33:0] mul_a, mul_b;

   // operand selection
   logic [15:0] lg_sel;
   logic [16:0] lg_ext, lg_mag, lo_ext, lo_mag;
   logic [15:0] q_sel;
   logic [16:0] q_ext, q_mag;
   logic [6:0]  est;
   logic [7:0]  n_cmb, n_cmb_mag;
   logic [37:0] tq, nl;
   logic        r_ge;
   logic [29:0] tay_x, tay_q;
   logic [5:0]  m_shift;
   logic [7:0]  m_full;
   logic [63:0] sh_base, e_pos, e_neg;
   logic [38:0] e_val;
   logic [39:0] sc_w;
   logic [15:0] sc_val;
   logic [31:0] den;
   logic [47:0] sig_num, q_num;
   logic        div_ge;
   logic [49:0] sq_rb;
   logic        sq_ge;
   logic [49:0] sq_res_nx;
   logic [15:0] quat_o, quat_lane;
   logic [12:0] sig_p;
   logic [15:0] smax;
   logic [28:0] imp_w;

   always_comb begin
      unique case (job_ff[1:0])
         2'd0:    lg_sel = job.log_scale[0];
         2'd1:    lg_sel = job.log_scale[1];
         default: lg_sel = job.log_scale[2];
      endcase
      unique case (lane_ff)
         2'd0:    q_sel = job.rotation_raw[15:0];
         2'd1:    q_sel = job.rotation_raw[31:16];
         2'd2:    q_sel = job.rotation_raw[47:32];
         default: q_sel = job.rotation_raw[63:48];
      endcase
   end

   assign lg_ext = {lg_sel[15], lg_sel};
   assign lg_mag = lg_ext[16] ? (~lg_ext + 17'd1) : lg_ext;
   assign lo_ext = {job.opacity_logit[15], job.opacity_logit};
   assign lo_mag = lo_ext[16] ? (~lo_ext + 17'd1) : lo_ext;
   assign q_ext  = {q_sel[15], q_sel};
   assign q_mag  = q_ext[16] ? (~q_ext + 17'd1) : q_ext;

   // first guess of n = floor(t / ln2); at most one low, fixed in ST_FIX
   assign est       = prod_ff[30:24];
   assign n_cmb     = t_ff[16] ? (8'd0 - {1'b0, est} - 8'd1) : {1'b0, est};
   assign n_cmb_mag = n_cmb[7] ? (8'd0 - n_cmb) : n_cmb;
   assign tq        = {t_ff[16], t_ff, 20'd0};
   assign nl        = prod_ff[37:0];
   assign r_ge      = !r_ff[37] && (r_ff >= {8'd0, gsad_pkg::LN2_Q30});

   assign tay_x = prod_ff[59:30];
   assign tay_q = prod_ff[63:34];

   assign m_full  = 8'd0 - n_ff;
   assign m_shift = m_full[5:0];
   assign sh_base = {32'd0, sum_ff};
   assign e_pos   = sh_base << n_ff[2:0];
   assign e_neg   = (sh_base + (64'd1 << (m_shift - 6'd1))) >> m_shift;
   assign e_val   = n_ff[7] ? e_neg[38:0] : e_pos[38:0];
   assign sc_w    = {1'b0, e_val} + 40'd524288;
   assign sc_val  = (|sc_w[39:36]) ? gsad_pkg::SCALE_MAX : sc_w[35:20];
   assign den     = 32'd1073741824 + e_val[31:0];
   assign sig_num = 48'h0400_0000_0000 + {17'd0, den[31:1]};
   assign q_num   = {9'd0, q_mag, 22'd0} + {24'd0, nrm_ff[24:1]};

   assign div_ge = rem_ff >= dsh_ff;

   assign sq_rb     = sq_res_ff + {1'b0, sq_bit_ff};
   assign sq_ge     = {1'b0, sq_v_ff} >= sq_rb;
   assign sq_res_nx = sq_ge ? ((sq_res_ff >> 1) + {1'b0, sq_bit_ff}) : (sq_res_ff >> 1);

   assign sig_p     = quo_ff[12:0];
   assign quat_o    = (quo_ff > gsad_pkg::QUAT_ONE) ? gsad_pkg::QUAT_ONE : quo_ff;
   assign quat_lane = neg_ff ? (16'd0 - quat_o) : quat_o;

   always_comb begin
      smax = res_ff.scale[0];
      if (res_ff.scale[1] > smax) smax = res_ff.scale[1];
      if (res_ff.scale[2] > smax) smax = res_ff.scale[2];
   end
   assign imp_w = prod_ff[28:0] + 29'd2048;

   assign prod_in = {34'd0, mul_a} * {34'd0, mul_b};

   always_comb begin
      state_in  = state_ff;
      job_in    = job_ff;
      t_in      = t_ff;
      n_in      = n_ff;
      r_in      = r_ff;
      term_in   = term_ff;
      sum_in    = sum_ff;
      k_in      = k_ff;
      rem_in    = rem_ff;
      dsh_in    = dsh_ff;
      quo_in    = quo_ff;
      cnt_in    = cnt_ff;
      ss_in     = ss_ff;
      lane_in   = lane_ff;
      sq_v_in   = sq_v_ff;
      sq_res_in = sq_res_ff;
      sq_bit_in = sq_bit_ff;
      nrm_in    = nrm_ff;
      neg_in    = neg_ff;
      res_in    = res_ff;
      mul_a     = 34'd0;
      mul_b     = 34'd0;
      done      = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               job_in   = 3'd0;
               state_in = ST_JOB;
            end
         end
         ST_JOB: begin
            if (job_ff == JOB_QUAT) begin
               if (!job.has_rotation) begin
                  res_in.rotation = {48'd0, gsad_pkg::QUAT_ONE};
                  state_in = ST_IMP1;
               end else begin
                  lane_in  = 2'd0;
                  ss_in    = 33'd0;
                  state_in = ST_SQ;
               end
            end else if (job_ff == JOB_SIG) begin
               if (!job.has_opacity) begin
                  res_in.opacity = gsad_pkg::OPACITY_ONE;
                  job_in = job_ff + 3'd1;
               end else begin
                  t_in     = ~lo_mag + 17'd1;
                  neg_in   = lo_ext[16];
                  mul_a    = {17'd0, lo_mag};
                  mul_b    = {19'd0, gsad_pkg::RECIP_LN2};
                  state_in = ST_RED1;
               end
            end else begin
               if (!job.has_scale) begin
                  res_in.scale[job_ff[1:0]] = gsad_pkg::DEFAULT_SCALE;
                  job_in = job_ff + 3'd1;
               end else if ($signed(lg_sel) >= gsad_pkg::SCALE_SAT_LOG) begin
                  res_in.scale[job_ff[1:0]] = gsad_pkg::SCALE_MAX;
                  job_in = job_ff + 3'd1;
               end else begin
                  t_in     = lg_ext;
                  mul_a    = {17'd0, lg_mag};
                  mul_b    = {19'd0, gsad_pkg::RECIP_LN2};
                  state_in = ST_RED1;
               end
            end
         end
         ST_RED1: begin
            n_in     = n_cmb;
            mul_a    = {26'd0, n_cmb_mag};
            mul_b    = {4'd0, gsad_pkg::LN2_Q30};
            state_in = ST_RED2;
         end
         ST_RED2: begin
            r_in     = n_ff[7] ? (tq + nl) : (tq - nl);
            state_in = ST_FIX;
         end
         ST_FIX: begin
            // walk r into [0, ln2)
            if (r_ff[37]) begin
               r_in = r_ff + {8'd0, gsad_pkg::LN2_Q30};
               n_in = n_ff - 8'd1;
            end else if (r_ge) begin
               r_in = r_ff - {8'd0, gsad_pkg::LN2_Q30};
               n_in = n_ff + 8'd1;
            end else begin
               term_in  = 31'd1073741824;
               sum_in   = 32'd1073741824;
               k_in     = 4'd1;
               state_in = ST_T1;
            end
         end
         ST_T1: begin
            mul_a    = {3'd0, term_ff};
            mul_b    = {4'd0, r_ff[29:0]};
            state_in = ST_T2;
         end
         ST_T2: begin
            if (k_ff == 4'd1) begin
               term_in  = {1'b0, tay_x};
               sum_in   = sum_ff + {2'd0, tay_x};
               k_in     = 4'd2;
               state_in = ST_T1;
            end else begin
               mul_a    = {4'd0, tay_x};
               mul_b    = gsad_pkg::taylor_recip(k_ff);
               state_in = ST_T3;
            end
         end
         ST_T3: begin
            term_in = {1'b0, tay_q};
            sum_in  = sum_ff + {2'd0, tay_q};
            if (k_ff == gsad_pkg::TAYLOR_TERMS) begin
               state_in = ST_SHIFT;
            end else begin
               k_in     = k_ff + 4'd1;
               state_in = ST_T1;
            end
         end
         ST_SHIFT: begin
            if (job_ff == JOB_SIG) begin
               rem_in   = sig_num;
               dsh_in   = {1'b0, den, 15'd0};
               quo_in   = 16'd0;
               cnt_in   = 4'd15;
               state_in = ST_DIV;
            end else begin
               res_in.scale[job_ff[1:0]] = sc_val;
               job_in   = job_ff + 3'd1;
               state_in = ST_JOB;
            end
         end
         ST_DIV: begin
            if (div_ge) rem_in = rem_ff - dsh_ff;
            quo_in = {quo_ff[14:0], div_ge};
            dsh_in = dsh_ff >> 1;
            cnt_in = cnt_ff - 4'd1;
            if (cnt_ff == 4'd0) state_in = ST_DIVEND;
         end
         ST_DIVEND: begin
            if (job_ff == JOB_SIG) begin
               res_in.opacity = neg_ff ? (gsad_pkg::OPACITY_ONE - sig_p) : sig_p;
               job_in   = job_ff + 3'd1;
               state_in = ST_JOB;
            end else begin
               res_in.rotation[lane_ff] = quat_lane;
               if (lane_ff == 2'd3) begin
                  state_in = ST_IMP1;
               end else begin
                  lane_in  = lane_ff + 2'd1;
                  state_in = ST_QSET;
               end
            end
         end
         ST_SQ: begin
            mul_a    = {17'd0, q_mag};
            mul_b    = {17'd0, q_mag};
            state_in = ST_SQA;
         end
         ST_SQA: begin
            ss_in   = ss_ff + prod_ff[32:0];
            lane_in = lane_ff + 2'd1;
            state_in = (lane_ff == 2'd3) ? ST_SQCHK : ST_SQ;
         end
         ST_SQCHK: begin
            if (ss_ff == 33'd0) begin
               res_in.rotation = {48'd0, gsad_pkg::QUAT_ONE};
               state_in = ST_IMP1;
            end else begin
               sq_v_in   = {ss_ff, 16'd0};
               sq_res_in = 50'd0;
               sq_bit_in = 49'd1 << 48;
               state_in  = ST_SQRT;
            end
         end
         ST_SQRT: begin
            if (sq_ge) sq_v_in = sq_v_ff - sq_rb[48:0];
            sq_res_in = sq_res_nx;
            sq_bit_in = sq_bit_ff >> 2;
            if (sq_bit_ff[0]) begin
               nrm_in   = sq_res_nx[24:0];
               lane_in  = 2'd0;
               state_in = ST_QSET;
            end
         end
         ST_QSET: begin
            neg_in   = q_ext[16];
            rem_in   = q_num;
            dsh_in   = {8'd0, nrm_ff, 15'd0};
            quo_in   = 16'd0;
            cnt_in   = 4'd15;
            state_in = ST_DIV;
         end
         ST_IMP1: begin
            mul_a    = {21'd0, res_ff.opacity};
            mul_b    = {18'd0, smax};
            state_in = ST_IMP2;
         end
         ST_IMP2: begin
            res_in.importance = (|imp_w[28:28]) ? gsad_pkg::SCALE_MAX : imp_w[27:12];
            state_in = ST_DONE;
         end
         ST_DONE: begin
            done = 1'b1;
            if (ack) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff    <= job_in;
      t_ff      <= t_in;
      n_ff      <= n_in;
      r_ff      <= r_in;
      term_ff   <= term_in;
      sum_ff    <= sum_in;
      k_ff      <= k_in;
      prod_ff   <= prod_in;
      rem_ff    <= rem_in;
      dsh_ff    <= dsh_in;
      quo_ff    <= quo_in;
      cnt_ff    <= cnt_in;
      ss_ff     <= ss_in;
      lane_ff   <= lane_in;
      sq_v_ff   <= sq_v_in;
      sq_res_ff <= sq_res_in;
      sq_bit_ff <= sq_bit_in;
      nrm_ff    <= nrm_in;
      neg_ff    <= neg_in;
      res_ff    <= res_in;
   end

   assign res = res_ff;

endmodule

`default_nettype wire

// ----- rtl/gaussian_splat_attribute_decode.sv -----
// Top level of the splat attribute decoder: handshakes, control registers,
// colour and bounding box, result register. Depends on gsad_pkg, gsad_engine.
//
// One splat is taken per beat on req_ and one decoded splat leaves per beat on
// rsp_. After a beat is taken, req_ready stays low until the engine has put its
// result in the output register; a finished result may wait there while the
// next splat is taken. The engine runs exp, sigmoid, square root and divide on
// one shared multiplier and separate shift-subtract loops for divide and square
// root. An exponential is run for each of the three scales and the opacity; a
// divide (set-up, 16 steps and write-back) for the opacity and each of the four
// quaternion lanes; squares, square root and importance complete the item.
// Absent attributes skip their part. Colour, bone and bounding box are settled
// in the accept cycle. The bounding box restarts on a splat with new_cloud set.
`default_nettype none

module gaussian_splat_attribute_decode (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [19:0] req_pos_x,
   input  wire logic [19:0] req_pos_y,
   input  wire logic [19:0] req_pos_z,
   input  wire logic [15:0] req_log_scale_x,
   input  wire logic [15:0] req_log_scale_y,
   input  wire logic [15:0] req_log_scale_z,
   input  wire logic [63:0] req_rotation_raw,
   input  wire logic [47:0] req_color_raw,
   input  wire logic [15:0] req_opacity_logit,
   input  wire logic [7:0]  req_bone_in,
   input  wire logic        req_new_cloud,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [15:0]      rsp_scale_x,
   output logic [15:0]      rsp_scale_y,
   output logic [15:0]      rsp_scale_z,
   output logic [63:0]      rsp_rotation_unit,
   output logic [35:0]      rsp_color_rgb,
   output logic [12:0]      rsp_opacity,
   output logic [15:0]      rsp_importance,
   output logic [7:0]       rsp_bone_out,
   output logic [59:0]      rsp_box_min,
   output logic [59:0]      rsp_box_max,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [0:0]  csr_wdata
);

   function automatic logic [11:0] color_lane(input logic [15:0] v, input logic sh);
      logic signed [33:0] w;
      logic signed [16:0] c;
      logic [11:0]        r;
      w = $signed({{18{v[15]}}, v}) * $signed({19'd0, gsad_pkg::SH_C0_Q16})
          + 34'sd67125248;
      c = sh ? (w[33] ? 17'sd0 : $signed({1'b0, w[30:15]})) : $signed({v[15], v});
      if (c < 17'sd0) r = 12'd0;
      else if (c > 17'sd4095) r = gsad_pkg::COLOR_MAX;
      else r = c[11:0];
      return r;
   endfunction

   logic has_scale_ff, has_rotation_ff, has_color_ff, color_is_sh_ff;
   logic has_opacity_ff, has_bone_ff;
   logic busy_ff, start_ff, rsp_valid_ff;
   logic [59:0] bound_lo_ff, bound_hi_ff, box_lo_in, box_hi_in;
   logic [59:0] pend_lo_ff, pend_hi_ff;
   logic [35:0] pend_color_ff, color_in;
   logic [7:0]  pend_bone_ff;
   gsad_pkg::gsad_job_type job_ff;
   gsad_pkg::gsad_res_type eng_res;
   logic        eng_done, load;
   logic        req_take;
   logic [2:0][19:0] pos;

   logic [15:0] out_sx_ff, out_sy_ff, out_sz_ff, out_imp_ff;
   logic [63:0] out_rot_ff;
   logic [35:0] out_col_ff;
   logic [12:0] out_op_ff;
   logic [7:0]  out_bone_ff;
   logic [59:0] out_lo_ff, out_hi_ff;

   assign req_ready = !busy_ff;
   assign req_take  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign load      = eng_done && (!rsp_valid_ff || rsp_ready);

   assign pos = {req_pos_z, req_pos_y, req_pos_x};

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (req_new_cloud) begin
            box_lo_in[20*i +: 20] = pos[i];
            box_hi_in[20*i +: 20] = pos[i];
         end else begin
            box_lo_in[20*i +: 20] = ($signed(pos[i]) < $signed(bound_lo_ff[20*i +: 20]))
                                    ? pos[i] : bound_lo_ff[20*i +: 20];
            box_hi_in[20*i +: 20] = ($signed(pos[i]) > $signed(bound_hi_ff[20*i +: 20]))
                                    ? pos[i] : bound_hi_ff[20*i +: 20];
         end
         color_in[12*i +: 12] = has_color_ff
                                ? color_lane(req_color_raw[16*i +: 16], color_is_sh_ff)
                                : gsad_pkg::COLOR_MAX;
      end
   end

   // control registers: only bit 0 is kept, unknown indexes drop
   always_ff @(posedge clock) begin
      if (reset) begin
         has_scale_ff    <= 1'b1;
         has_rotation_ff <= 1'b1;
         has_color_ff    <= 1'b1;
         color_is_sh_ff  <= 1'b1;
         has_opacity_ff  <= 1'b1;
         has_bone_ff     <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            gsad_pkg::CSR_HAS_SCALE:    has_scale_ff    <= csr_wdata[0];
            gsad_pkg::CSR_HAS_ROTATION: has_rotation_ff <= csr_wdata[0];
            gsad_pkg::CSR_HAS_COLOR:    has_color_ff    <= csr_wdata[0];
            gsad_pkg::CSR_COLOR_IS_SH:  color_is_sh_ff  <= csr_wdata[0];
            gsad_pkg::CSR_HAS_OPACITY:  has_opacity_ff  <= csr_wdata[0];
            gsad_pkg::CSR_HAS_BONE:     has_bone_ff     <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         bound_lo_ff  <= {3{gsad_pkg::LANE_POS_MAX}};
         bound_hi_ff  <= {3{gsad_pkg::LANE_NEG_MAX}};
      end else begin
         start_ff <= req_take;
         if (req_take) begin
            busy_ff     <= 1'b1;
            bound_lo_ff <= box_lo_in;
            bound_hi_ff <= box_hi_in;
         end else if (load) begin
            busy_ff <= 1'b0;
         end
         if (load) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         job_ff.log_scale     <= {req_log_scale_z, req_log_scale_y, req_log_scale_x};
         job_ff.opacity_logit <= req_opacity_logit;
         job_ff.rotation_raw  <= req_rotation_raw;
         job_ff.has_scale     <= has_scale_ff;
         job_ff.has_rotation  <= has_rotation_ff;
         job_ff.has_opacity   <= has_opacity_ff;
         pend_color_ff        <= color_in;
         pend_bone_ff         <= has_bone_ff ? req_bone_in : 8'd0;
         pend_lo_ff           <= box_lo_in;
         pend_hi_ff           <= box_hi_in;
      end
      if (load) begin
         out_sx_ff   <= eng_res.scale[0];
         out_sy_ff   <= eng_res.scale[1];
         out_sz_ff   <= eng_res.scale[2];
         out_rot_ff  <= eng_res.rotation;
         out_op_ff   <= eng_res.opacity;
         out_imp_ff  <= eng_res.importance;
         out_col_ff  <= pend_color_ff;
         out_bone_ff <= pend_bone_ff;
         out_lo_ff   <= pend_lo_ff;
         out_hi_ff   <= pend_hi_ff;
      end
   end

   gsad_engine u_engine (
      .clock (clock),
      .reset (reset),
      .start (start_ff),
      .job   (job_ff),
      .ack   (load),
      .done  (eng_done),
      .res   (eng_res)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_scale_x       = out_sx_ff;
   assign rsp_scale_y       = out_sy_ff;
   assign rsp_scale_z       = out_sz_ff;
   assign rsp_rotation_unit = out_rot_ff;
   assign rsp_color_rgb     = out_col_ff;
   assign rsp_opacity       = out_op_ff;
   assign rsp_importance    = out_imp_ff;
   assign rsp_bone_out      = out_bone_ff;
   assign rsp_box_min       = out_lo_ff;
   assign rsp_box_max       = out_hi_ff;

endmodule

`default_nettype wire

// ----- rtl/gsad_checker.sv -----
// Port-level checks for the splat attribute decoder, bound to its top level.
// Depends only on the ports of gaussian_splat_attribute_decode.
`default_nettype none

module gsad_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [15:0] rsp_scale_x,
   input wire logic [12:0] rsp_opacity,
   input wire logic [59:0] rsp_box_min,
   input wire logic [59:0] rsp_box_max
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second beat taken while an item is in flight");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_scale_x) && $stable(rsp_box_min))
      else $error("stalled result changed");

   a_result_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_opacity <= 13'd4096
         && $signed(rsp_box_min[19:0])  <= $signed(rsp_box_max[19:0])
         && $signed(rsp_box_min[39:20]) <= $signed(rsp_box_max[39:20])
         && $signed(rsp_box_min[59:40]) <= $signed(rsp_box_max[59:40]))
      else $error("opacity above one or box corners crossed");

endmodule

bind gaussian_splat_attribute_decode gsad_checker u_gsad_checker (.*);

`default_nettype wire

// ----- bench/tb_gaussian_splat_attribute_decode.sv -----
// Self-checking bench for the splat attribute decoder: drives raw splats and
// register writes, predicts each decoded splat in fixed point, checks rsp_ beats.
// Depends on gsad_pkg and gaussian_splat_attribute_decode.
`timescale 1ns / 1ps

module tb_gaussian_splat_attribute_decode;

   typedef struct packed {
      logic [19:0] pos_x, pos_y, pos_z;
      logic [15:0] ls_x, ls_y, ls_z;
      logic [63:0] rot;
      logic [47:0] col;
      logic [15:0] logit;
      logic [7:0]  bone;
      logic        new_cloud;
   } splat_type;

   typedef struct packed {
      logic [15:0] scale_x, scale_y, scale_z;
      logic [63:0] rot;
      logic [35:0] col;
      logic [12:0] opacity;
      logic [15:0] importance;
      logic [7:0]  bone;
      logic [59:0] box_min, box_max;
   } decoded_type;

   localparam longint LIMIT = 4_000_000;

   logic clock = 0, reset = 1;
   logic req_valid = 0, rsp_ready = 0, csr_valid = 0;
   splat_type req = '0;
   logic [2:0] csr_index = '0;
   logic [0:0] csr_wdata = '0;
   logic req_ready, rsp_valid, csr_ready;
   decoded_type got;

   // predictor state
   logic flag_scale, flag_rot, flag_col, flag_sh, flag_op, flag_bone;
   logic [59:0] box_lo, box_hi;
   decoded_type pending[$];
   int  errors = 0;
   longint cycles = 0;
   int  hold_off = 0;
   bit  rx_random = 1;

   gaussian_splat_attribute_decode uut (
      .clock, .reset,
      .req_valid, .req_ready,
      .req_pos_x(req.pos_x), .req_pos_y(req.pos_y), .req_pos_z(req.pos_z),
      .req_log_scale_x(req.ls_x), .req_log_scale_y(req.ls_y),
      .req_log_scale_z(req.ls_z), .req_rotation_raw(req.rot),
      .req_color_raw(req.col), .req_opacity_logit(req.logit),
      .req_bone_in(req.bone), .req_new_cloud(req.new_cloud),
      .rsp_valid, .rsp_ready,
      .rsp_scale_x(got.scale_x), .rsp_scale_y(got.scale_y), .rsp_scale_z(got.scale_z),
      .rsp_rotation_unit(got.rot), .rsp_color_rgb(got.col), .rsp_opacity(got.opacity),
      .rsp_importance(got.importance), .rsp_bone_out(got.bone),
      .rsp_box_min(got.box_min), .rsp_box_max(got.box_max),
      .csr_valid, .csr_ready, .csr_index, .csr_wdata
   );

   initial begin
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // exp(t/1024) in Q30
   function automatic longint unsigned exp_fix(longint t);
      longint tq, n;
      longint unsigned r, term, sum, m;
      tq = t * 1048576;
      n = tq / 744261118;
      if (tq - n * 744261118 < 0) n--;
      r = tq - n * 744261118;
      term = 64'd1 << 30;
      sum = term;
      for (int k = 1; k <= 12; k++) begin
         term = ((term * r) >> 30) / k;
         sum += term;
      end
      if (n >= 0) return sum << n;
      m = -n;
      if (m >= 62) return 0;
      return (sum + (64'd1 << (m - 1))) >> m;
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v -= res + b;
            res = (res >> 1) + b;
         end else res >>= 1;
         b >>= 2;
      end
      return res;
   endfunction

   function automatic logic [15:0] scale_of(logic signed [15:0] l);
      longint unsigned s;
      if (flag_scale == 0) return gsad_pkg::DEFAULT_SCALE;
      if (l >= 4352) return 16'hFFFF;
      s = (exp_fix(l) + (64'd1 << 19)) >> 20;
      return s > 65535 ? 16'hFFFF : s[15:0];
   endfunction

   function automatic decoded_type decode_splat(splat_type s);
      decoded_type d;
      longint q[4], a, v, w, c, p, lo, hi;
      longint unsigned ss, nrm, mag, o, den, op, smax, imp;
      logic [15:0] lane;
      d = '0;
      d.scale_x = scale_of(s.ls_x);
      d.scale_y = scale_of(s.ls_y);
      d.scale_z = scale_of(s.ls_z);
      d.rot = 64'(gsad_pkg::QUAT_ONE);
      if (flag_rot) begin
         ss = 0;
         for (int i = 0; i < 4; i++) begin
            q[i] = $signed(s.rot[16*i +: 16]);
            ss += q[i] * q[i];
         end
         if (ss != 0) begin
            nrm = int_sqrt(ss << 16);
            for (int i = 0; i < 4; i++) begin
               mag = q[i] < 0 ? -q[i] : q[i];
               o = ((mag << 22) + (nrm >> 1)) / nrm;
               if (o > 16384) o = 16384;
               lane = q[i] < 0 ? 16'(-o) : 16'(o);
               d.rot[16*i +: 16] = lane;
            end
         end
      end
      for (int i = 0; i < 3; i++) begin
         if (!flag_col) c = 4095;
         else begin
            v = $signed(s.col[16*i +: 16]);
            if (flag_sh) begin
               w = v * 18487 + 2048 * 32768 + 16384;
               c = w < 0 ? 0 : w / 32768;
            end else c = v;
            if (c < 0) c = 0;
            if (c > 4095) c = 4095;
         end
         d.col[12*i +: 12] = c[11:0];
      end
      if (flag_op) begin
         a = $signed(s.logit);
         if (a < 0) a = -a;
         den = (64'd1 << 30) + exp_fix(-a);
         op = ((64'd1 << 42) + (den >> 1)) / den;
         if ($signed(s.logit) < 0) op = 4096 - op;
      end else op = 4096;
      d.opacity = op[12:0];
      smax = d.scale_x;
      if (d.scale_y > smax) smax = d.scale_y;
      if (d.scale_z > smax) smax = d.scale_z;
      imp = (op * smax + 2048) >> 12;
      d.importance = imp > 65535 ? 16'hFFFF : imp[15:0];
      d.bone = flag_bone ? s.bone : 8'd0;
      for (int i = 0; i < 3; i++) begin
         p = $signed(i == 0 ? s.pos_x : i == 1 ? s.pos_y : s.pos_z);
         lo = $signed(box_lo[20*i +: 20]);
         hi = $signed(box_hi[20*i +: 20]);
         if (s.new_cloud) begin
            lo = p;
            hi = p;
         end else begin
            if (p < lo) lo = p;
            if (p > hi) hi = p;
         end
         box_lo[20*i +: 20] = lo[19:0];
         box_hi[20*i +: 20] = hi[19:0];
      end
      d.box_min = box_lo;
      d.box_max = box_hi;
      return d;
   endfunction

   // receiver stall pattern, with a long hold-off when asked
   always @(posedge clock) begin
      if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_ready <= 0;
      end else rsp_ready <= rx_random ? ($urandom_range(3) != 0) : 1'b1;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending.size() == 0) begin
            $error("result beat with nothing expected");
            errors++;
         end else begin
            decoded_type e;
            e = pending.pop_front();
            if (got.scale_x !== e.scale_x) begin
               $error("scale_x exp %h got %h", e.scale_x, got.scale_x); errors++;
            end
            if (got.scale_y !== e.scale_y) begin
               $error("scale_y exp %h got %h", e.scale_y, got.scale_y); errors++;
            end
            if (got.scale_z !== e.scale_z) begin
               $error("scale_z exp %h got %h", e.scale_z, got.scale_z); errors++;
            end
            if (got.rot !== e.rot) begin
               $error("rotation_unit exp %h got %h", e.rot, got.rot); errors++;
            end
            if (got.col !== e.col) begin
               $error("color_rgb exp %h got %h", e.col, got.col); errors++;
            end
            if (got.opacity !== e.opacity) begin
               $error("opacity exp %h got %h", e.opacity, got.opacity); errors++;
            end
            if (got.importance !== e.importance) begin
               $error("importance exp %h got %h", e.importance, got.importance); errors++;
            end
            if (got.bone !== e.bone) begin
               $error("bone_out exp %h got %h", e.bone, got.bone); errors++;
            end
            if (got.box_min !== e.box_min) begin
               $error("box_min exp %h got %h", e.box_min, got.box_min); errors++;
            end
            if (got.box_max !== e.box_max) begin
               $error("box_max exp %h got %h", e.box_max, got.box_max); errors++;
            end
         end
      end
   end

   task automatic send_splat(splat_type s);
      req_valid <= 1;
      req <= s;
      do @(posedge clock); while (!req_ready);
      pending.insert(pending.size(), decode_splat(s));
      // random burst gaps with req_valid low
      if ($urandom_range(3) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(6, 1)) @(posedge clock);
      end
   endtask

   task automatic idle_bench();
      req_valid <= 0;
      @(posedge clock);
      while (pending.size() != 0) @(posedge clock);
      repeat (400) @(posedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, logic val);
      csr_valid <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
      case (idx)
         gsad_pkg::CSR_HAS_SCALE:    flag_scale = val;
         gsad_pkg::CSR_HAS_ROTATION: flag_rot = val;
         gsad_pkg::CSR_HAS_COLOR:    flag_col = val;
         gsad_pkg::CSR_COLOR_IS_SH:  flag_sh = val;
         gsad_pkg::CSR_HAS_OPACITY:  flag_op = val;
         gsad_pkg::CSR_HAS_BONE:     flag_bone = val;
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic write_all(logic [5:0] f);
      write_reg(gsad_pkg::CSR_HAS_SCALE, f[0]);
      write_reg(gsad_pkg::CSR_HAS_ROTATION, f[1]);
      write_reg(gsad_pkg::CSR_HAS_COLOR, f[2]);
      write_reg(gsad_pkg::CSR_COLOR_IS_SH, f[3]);
      write_reg(gsad_pkg::CSR_HAS_OPACITY, f[4]);
      write_reg(gsad_pkg::CSR_HAS_BONE, f[5]);
   endtask

   function automatic splat_type random_splat();
      splat_type s;
      logic [319:0] raw;
      raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
             $urandom, $urandom, $urandom};
      s = raw[$bits(splat_type)-1:0];
      // keep most log scales and logits in the interesting band
      if ($urandom_range(3) != 0) begin
         s.ls_x = 16'($signed($urandom_range(9000)) - 5000);
         s.ls_y = 16'($signed($urandom_range(9000)) - 5000);
         s.ls_z = 16'($signed($urandom_range(9000)) - 5000);
         s.logit = 16'($signed($urandom_range(20000)) - 10000);
      end
      if ($urandom_range(7) == 0) s.rot = '0;
      s.new_cloud = ($urandom_range(15) == 0);
      return s;
   endfunction

   task automatic test_directed();
      splat_type s;
      s = '0;
      s.new_cloud = 1;
      send_splat(s);            // zero quaternion, mid values
      s = '0;
      s.pos_x = 20'h7FFFF; s.pos_y = 20'h80000; s.pos_z = 20'hFFFFF;
      s.ls_x = 16'h7FFF; s.ls_y = 16'h8000; s.ls_z = 16'd4351;
      s.rot = {16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF};
      s.col = {16'h7FFF, 16'h8000, 16'h0FFF};
      s.logit = 16'h7FFF; s.bone = 8'hFF;
      send_splat(s);
      s.ls_x = 16'd4352; s.logit = 16'h8000; s.rot = 64'h0000_0000_0000_4000;
      s.col = 48'hFFFF_FFFF_FFFF; s.bone = 8'h00;
      send_splat(s);
      s.logit = 16'd0; s.ls_y = 16'd0; s.col = {16'd0, 16'h1000, 16'hF000};
      s.rot = 64'hFFFF_0001_FFFF_0001;
      send_splat(s);
      s.pos_x = 20'h80000; s.pos_y = 20'h7FFFF; s.new_cloud = 1;
      send_splat(s);
      for (int i = 0; i < 10; i++) send_splat(random_splat());
      idle_bench();
   endtask

   task automatic test_register_settings();
      logic [5:0] cfg[4] = '{6'b000000, 6'b111111, 6'b110101, 6'b001010};
      foreach (cfg[i]) begin
         write_all(cfg[i]);
         for (int n = 0; n < 25; n++) send_splat(random_splat());
         idle_bench();
      end
      // unknown indexes change nothing
      write_reg(3'd6, 1'b1);
      write_reg(3'd7, 1'b0);
      write_all(6'b011111);
   endtask

   task automatic test_backpressure();
      rx_random = 1;
      hold_off = 3000;
      for (int n = 0; n < 20; n++) send_splat(random_splat());
      idle_bench();
   endtask

   task automatic test_random();
      for (int n = 0; n < 1900; n++) begin
         if (n % 400 == 399) begin
            idle_bench();
            write_all(6'($urandom));
            rx_random = $urandom_range(1);
         end
         send_splat(random_splat());
      end
      idle_bench();
   endtask

   initial begin
      flag_scale = 1; flag_rot = 1; flag_col = 1;
      flag_sh = 1; flag_op = 1; flag_bone = 0;
      box_lo = {3{gsad_pkg::LANE_POS_MAX}};
      box_hi = {3{gsad_pkg::LANE_NEG_MAX}};
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      test_directed();
      test_register_settings();
      test_backpressure();
      test_random();
      if (errors == 0 && pending.size() == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// ----- gaussian_splat_attribute_decode.f -----
rtl/gsad_pkg.sv
rtl/gsad_engine.sv
rtl/gaussian_splat_attribute_decode.sv
rtl/gsad_checker.sv
bench/tb_gaussian_splat_attribute_decode.sv
